@@ rtl/core/srt_pkg.sv @@
// shared types and codes for the stream reassembly tracker
package srt_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] ST_SEGMENT  = 3'd0;
    localparam logic [2:0] ST_CLOSE    = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [19:0] COUNT_MAX   = 20'hFFFFF;
    localparam int          RESULT_LIMIT = 16;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [63:0] chunk_start;
        logic [15:0] chunk_length;
        logic [31:0] buffer_handle;
        logic [19:0] max_bytes;
    } req_fields_t;

    typedef struct packed {
        op_t         op;
        req_fields_t f;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] stream_offset;
        logic [31:0] segment_handle;
        logic [15:0] offset_in_chunk;
        logic [15:0] copy_length;
        logic        is_last;
        logic [19:0] available_bytes;
        logic [19:0] held_bytes;
    } res_t;

endpackage

@@ rtl/core/srt_front.sv @@
// request intake: decodes the kind and queues commands for the engine
module srt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_kind,
    input  srt_pkg::req_fields_t s_fields,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output srt_pkg::cmd_t       cmd
);
    import srt_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    op_t        op;
    logic       push, pop;

    always_comb begin
        keep = 1'b1;
        op   = OP_INSERT;
        unique case (s_kind)
            KIND_INSERT: op = OP_INSERT;
            KIND_READ:   op = OP_READ;
            KIND_CLEAR:  op = OP_CLEAR;
            default:     keep = 1'b0;
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{op: op, f: s_fields};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");
`endif

endmodule

@@ rtl/core/srt_engine.sv @@
// descriptor table engine: insert, read and clear with a sequential scan
module srt_engine #(
    parameter int TABLE_ENTRIES   = 16,
    parameter int MAX_CHUNK_BYTES = 65535
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  srt_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output srt_pkg::res_t res
);
    import srt_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_RAW = $clog2(TABLE_ENTRIES * MAX_CHUNK_BYTES + 1);
    localparam int CNT_W   = (CNT_RAW > 16) ? CNT_RAW : 17;
    localparam int WIDE_W  = (CNT_W > 20) ? CNT_W : 20;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_SCAN = 7'b0000010,
        S_INS_PUT  = 7'b0000100,
        S_RECOUNT  = 7'b0001000,
        S_RESULT   = 7'b0010000,
        S_RD_SIZE  = 7'b0100000,
        S_RD_EMIT  = 7'b1000000
    } state_t;

    logic [63:0] start_arr  [TABLE_ENTRIES];
    logic [15:0] len_arr    [TABLE_ENTRIES];
    logic [31:0] handle_arr [TABLE_ENTRIES];

    state_t           state_reg, state_next;
    logic [IDX_W:0]   used_reg, used_next;
    logic [IDX_W:0]   idx_reg, idx_next;
    logic [IDX_W:0]   pos_reg, pos_next;
    logic             found_reg, found_next;
    logic [63:0]      rd_off_reg, rd_off_next;
    logic [CNT_W-1:0] contig_reg, contig_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [63:0]      end_reg, end_next;
    logic [2:0]       status_reg, status_next;
    logic [63:0]      so_reg, so_next;
    cmd_t             cmd_reg, cmd_next;
    logic             ov_reg, ov_next;
    res_t             out_reg, out_next;
    logic             do_put, do_pop_entry;

    logic [63:0] e_start, e_end, e0_start;
    logic [15:0] e_len, e0_len;
    logic [31:0] e0_handle;
    logic [64:0] ins_sum;
    logic        out_free;
    logic [15:0] sz_off, sz_rem, sz_take;
    logic [15:0] em_off, em_rem, em_take;
    logic [CNT_W-1:0] m_bytes;
    logic [WIDE_W-1:0] contig_w, maxb_w;

    function automatic logic [19:0] sat(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] ext;
        ext = WIDE_W'(v);
        return (ext > WIDE_W'(COUNT_MAX)) ? COUNT_MAX : ext[19:0];
    endfunction

    assign e_start   = start_arr[idx_reg[IDX_W-1:0]];
    assign e_len     = len_arr[idx_reg[IDX_W-1:0]];
    assign e_end     = e_start + 64'(e_len);
    assign e0_start  = start_arr[0];
    assign e0_len    = len_arr[0];
    assign e0_handle = handle_arr[0];

    assign ins_sum   = {1'b0, cmd.f.chunk_start} + 65'(cmd.f.chunk_length);
    assign out_free  = !ov_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = ov_reg;
    assign res       = out_reg;

    assign contig_w = WIDE_W'(contig_reg);
    assign maxb_w   = WIDE_W'(cmd.f.max_bytes);
    assign m_bytes  = (contig_w < maxb_w) ? contig_reg : CNT_W'(cmd.f.max_bytes);

    assign sz_off  = (idx_reg == '0) ? 16'(rd_off_reg - e_start) : 16'd0;
    assign sz_rem  = e_len - sz_off;
    assign sz_take = (rem_reg < CNT_W'(sz_rem)) ? rem_reg[15:0] : sz_rem;

    assign em_off  = 16'(rd_off_reg - e0_start);
    assign em_rem  = e0_len - em_off;
    assign em_take = (rem_reg < CNT_W'(em_rem)) ? rem_reg[15:0] : em_rem;

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        rd_off_next  = rd_off_reg;
        contig_next  = contig_reg;
        held_next    = held_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        wr_next      = wr_reg;
        end_next     = end_reg;
        status_next  = status_reg;
        so_next      = so_reg;
        cmd_next     = cmd_reg;
        ov_next      = ov_reg && !res_ready;
        out_next     = out_reg;
        do_put       = 1'b0;
        do_pop_entry = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd;
                    so_next  = 64'd0;
                    idx_next = '0;
                    unique case (cmd.op)
                        OP_INSERT: begin
                            found_next = 1'b0;
                            end_next   = ins_sum[63:0];
                            if (cmd.f.chunk_length == 16'd0 ||
                                cmd.f.chunk_length > 16'(MAX_CHUNK_BYTES) ||
                                ins_sum[64] || cmd.f.chunk_start < rd_off_reg) begin
                                status_next = ST_REJECTED;
                                state_next  = S_RESULT;
                            end else begin
                                state_next = S_INS_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (m_bytes == '0) begin
                                status_next = (used_reg != '0) ? ST_CLOSE : ST_NONE;
                                so_next     = (used_reg != '0) ? rd_off_reg : 64'd0;
                                state_next  = S_RESULT;
                            end else begin
                                rem_next   = m_bytes;
                                wr_next    = '0;
                                state_next = S_RD_SIZE;
                            end
                        end
                        OP_CLEAR: begin
                            used_next   = '0;
                            rd_off_next = 64'd0;
                            contig_next = '0;
                            held_next   = '0;
                            status_next = ST_NONE;
                            state_next  = S_RESULT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_SCAN: begin
                if (idx_reg == used_reg) begin
                    if (used_reg == (IDX_W + 1)'(TABLE_ENTRIES)) begin
                        status_next = ST_FULL;
                        state_next  = S_RESULT;
                    end else begin
                        pos_next   = found_reg ? pos_reg : used_reg;
                        state_next = S_INS_PUT;
                    end
                end else if (cmd_reg.f.chunk_start < e_end && e_start < end_reg) begin
                    status_next = ST_REJECTED;
                    state_next  = S_RESULT;
                end else begin
                    if (!found_reg && e_start >= cmd_reg.f.chunk_start) begin
                        found_next = 1'b1;
                        pos_next   = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_INS_PUT: begin
                do_put      = 1'b1;
                used_next   = used_reg + 1'b1;
                held_next   = held_reg + CNT_W'(cmd_reg.f.chunk_length);
                status_next = ST_INSERTED;
                idx_next    = '0;
                state_next  = S_RECOUNT;
            end
            S_RECOUNT: begin
                if (idx_reg == used_reg) begin
                    contig_next = (idx_reg == '0) ? '0 : acc_reg;
                    state_next  = S_RESULT;
                end else if (idx_reg == '0) begin
                    if (e_start > rd_off_reg || e_end <= rd_off_reg) begin
                        contig_next = '0;
                        state_next  = S_RESULT;
                    end else begin
                        acc_next = CNT_W'(e_end - rd_off_reg);
                        end_next = e_end;
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (e_start == end_reg) begin
                    acc_next = acc_reg + CNT_W'(e_len);
                    end_next = e_end;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    contig_next = acc_reg;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    out_next = '{status: status_reg, stream_offset: so_reg,
                                 segment_handle: 32'd0, offset_in_chunk: 16'd0,
                                 copy_length: 16'd0, is_last: 1'b1,
                                 available_bytes: sat(contig_reg),
                                 held_bytes: sat(held_reg)};
                    state_next = S_IDLE;
                end
            end
            S_RD_SIZE: begin
                wr_next  = wr_reg + CNT_W'(sz_take);
                rem_next = rem_reg - CNT_W'(sz_take);
                idx_next = idx_reg + 1'b1;
                if (rem_reg <= CNT_W'(sz_rem) ||
                    idx_reg == (IDX_W + 1)'(RESULT_LIMIT - 1)) begin
                    contig_next = contig_reg - wr_next;
                    held_next   = held_reg - wr_next;
                    rem_next    = wr_next;
                    state_next  = S_RD_EMIT;
                end
            end
            S_RD_EMIT: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    out_next = '{status: ST_SEGMENT, stream_offset: rd_off_reg,
                                 segment_handle: e0_handle, offset_in_chunk: em_off,
                                 copy_length: em_take,
                                 is_last: (CNT_W'(em_take) == rem_reg),
                                 available_bytes: sat(contig_reg),
                                 held_bytes: sat(held_reg)};
                    rd_off_next = rd_off_reg + 64'(em_take);
                    rem_next    = rem_reg - CNT_W'(em_take);
                    if (em_take == em_rem) begin
                        do_pop_entry = 1'b1;
                        used_next    = used_reg - 1'b1;
                    end
                    if (CNT_W'(em_take) == rem_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            rd_off_reg <= 64'd0;
            contig_reg <= '0;
            held_reg   <= '0;
            ov_reg     <= 1'b0;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rd_off_reg <= rd_off_next;
            contig_reg <= contig_next;
            held_reg   <= held_next;
            ov_reg     <= ov_next;
            found_reg  <= found_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        wr_reg     <= wr_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        so_reg     <= so_next;
        cmd_reg    <= cmd_next;
        out_reg    <= out_next;
    end

    // table storage: open a slot on insert, drop the head once read out
    always_ff @(posedge aclk) begin
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (do_put) begin
                if ((IDX_W + 1)'(j) == pos_reg) begin
                    start_arr[j]  <= cmd_reg.f.chunk_start;
                    len_arr[j]    <= cmd_reg.f.chunk_length;
                    handle_arr[j] <= cmd_reg.f.buffer_handle;
                end else if (j > 0 && (IDX_W + 1)'(j) > pos_reg &&
                             (IDX_W + 1)'(j) <= used_reg) begin
                    start_arr[j]  <= start_arr[(j > 0) ? j - 1 : 0];
                    len_arr[j]    <= len_arr[(j > 0) ? j - 1 : 0];
                    handle_arr[j] <= handle_arr[(j > 0) ? j - 1 : 0];
                end
            end else if (do_pop_entry && j < TABLE_ENTRIES - 1) begin
                start_arr[j]  <= start_arr[(j < TABLE_ENTRIES - 1) ? j + 1 : j];
                len_arr[j]    <= len_arr[(j < TABLE_ENTRIES - 1) ? j + 1 : j];
                handle_arr[j] <= handle_arr[(j < TABLE_ENTRIES - 1) ? j + 1 : j];
            end
        end
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= (IDX_W + 1)'(TABLE_ENTRIES))
        else $error("table count beyond capacity");
    a_contig_le_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> contig_reg <= held_reg)
        else $error("contiguous count above held count");
    a_empty_nothing_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && used_reg == '0 |-> held_reg == '0)
        else $error("bytes held with an empty table");
    a_emit_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD_EMIT |-> rem_reg != '0)
        else $error("segment emission with nothing left");
`endif

endmodule

@@ rtl/core/stream_reassembly_tracker_core.sv @@
// top level: out-of-order reassembly tracker with stream request and result ports
// Keeps up to TABLE_ENTRIES chunk descriptors sorted by stream offset. Requests
// (tuser: 0 insert, 1 read, 2 clear, 3 ignored) pass through a two-deep queue to a
// table engine that walks the table one entry per cycle through a single scan index.
// An insert runs an overlap scan, then the contiguity recount; a read runs a sizing pass,
// then emits one segment per cycle while the result port accepts them; a clear or an
// empty read goes straight to its result. Each result waits in an output register,
// so a stalled result port holds the engine only.
module stream_reassembly_tracker_core #(
    parameter int TABLE_ENTRIES   = 16,
    parameter int MAX_CHUNK_BYTES = 65535
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // chunk_start[63:0], chunk_length[79:64], buffer_handle[111:80],
    // max_bytes[131:112], zero fill
    input  logic [135:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // stream_offset[63:0], segment_handle[95:64], offset_in_chunk[111:96],
    // copy_length[127:112], available_bytes[147:128], held_bytes[167:148]
    output logic [167:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import srt_pkg::*;

    req_fields_t fields;
    cmd_t        cmd;
    logic        cmd_valid, cmd_ready;
    res_t        res;

    assign fields = '{chunk_start: s_tdata[63:0], chunk_length: s_tdata[79:64],
                      buffer_handle: s_tdata[111:80], max_bytes: s_tdata[131:112]};

    srt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .s_fields  (fields),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    srt_engine #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.held_bytes, res.available_bytes, res.copy_length,
                      res.offset_in_chunk, res.segment_handle, res.stream_offset};
    assign m_tuser = res.status;
    assign m_tlast = res.is_last;

endmodule
